// ===== sv/assert_macros.svh =====
// Assertion macros used by the top level of the prime size lookup.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define NPAL_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("Assertion failed: same-cycle implication.");
`define NPAL_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("Assertion failed: next-cycle implication.");
`else
`define NPAL_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define NPAL_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== sv/npal_pkg.sv =====
// Package with constants, the prime table and the control types of the prime size lookup.
package npal_pkg;

   localparam int LIST_LEN          = 72;
   localparam int DEF_TABLE_ENTRIES = 72;
   localparam int IDX_W             = $clog2(LIST_LEN);
   localparam int ENTRY_W           = 23;
   localparam int MIN_W             = 32;
   localparam int SIZE_W            = 31;
   localparam int DIV_W             = 16;
   localparam int SQ_W              = 32;
   localparam int BIT_W             = $clog2(SIZE_W);

   localparam logic [SIZE_W-1:0] SEARCH_LIMIT = 31'h7FFF_FFFF;
   localparam logic [DIV_W-1:0]  FIRST_DIV    = 16'd3;
   localparam logic [SQ_W-1:0]   FIRST_SQ     = 32'd9;
   localparam logic [BIT_W-1:0]  CAND_MSB     = BIT_W'(SIZE_W - 1);

   localparam logic [ENTRY_W-1:0] PRIME_LIST [LIST_LEN] = '{
      23'd3, 23'd7, 23'd11, 23'd17, 23'd23, 23'd29, 23'd37, 23'd47, 23'd59, 23'd71,
      23'd89, 23'd107, 23'd131, 23'd163, 23'd197, 23'd239, 23'd293, 23'd353, 23'd431,
      23'd521, 23'd631, 23'd761, 23'd919, 23'd1103, 23'd1327, 23'd1597, 23'd1931,
      23'd2333, 23'd2801, 23'd3371, 23'd4049, 23'd4861, 23'd5839, 23'd7013, 23'd8419,
      23'd10103, 23'd12143, 23'd14591, 23'd17519, 23'd21023, 23'd25229, 23'd30293,
      23'd36353, 23'd43627, 23'd52361, 23'd62851, 23'd75431, 23'd90523, 23'd108631,
      23'd130363, 23'd156437, 23'd187751, 23'd225307, 23'd270371, 23'd324449,
      23'd389357, 23'd467237, 23'd560689, 23'd672827, 23'd807403, 23'd968897,
      23'd1162687, 23'd1395263, 23'd1674319, 23'd2009191, 23'd2411033, 23'd2893249,
      23'd3471899, 23'd4166287, 23'd4999559, 23'd5999471, 23'd7199369
   };

   typedef struct packed {
      logic load;
      logic scan_next;
      logic set_table;
      logic start_cand;
      logic set_fail;
      logic set_prime;
      logic init_div;
      logic start_rem;
      logic rem_step;
      logic next_div;
      logic next_cand;
      logic load_out;
   } npal_cmd_type;

   typedef struct packed {
      logic scan_hit;
      logic scan_last;
      logic min_small;
      logic cand_at_limit;
      logic sq_over;
      logic rem_last;
      logic rem_zero;
   } npal_sts_type;

endpackage

// ===== sv/npal_if.sv =====
// Request and response channel interfaces of the prime size lookup.
interface npal_req_if;
   logic                valid;
   logic                ready;
   logic signed [31:0]  min_size;

   modport source (output valid, output min_size, input ready);
   modport sink (input valid, input min_size, output ready);
endinterface

interface npal_rsp_if;
   logic         valid;
   logic         ready;
   logic [30:0]  prime_size;
   logic         found;

   modport source (output valid, output prime_size, output found, input ready);
   modport sink (input valid, input prime_size, input found, output ready);
endinterface

// ===== sv/next_prime_at_least_core.sv =====
// Top level of the prime size lookup: controller and datapath, with the response register in the datapath.
// For each request the block returns the first entry of its ascending prime table that is
// not below min_size, or, past the table, the next odd prime found by trial division with
// found set, or min_size itself with found clear when no candidate below 2147483647 remains.
// The table is scanned one entry per cycle. Past the table, each trial divisor takes a bound
// check, one step per bit of the 31-bit candidate in the one-bit-per-cycle restoring
// remainder unit and a remainder check; a composite candidate moves on to the next odd
// candidate, and a prime one ends at its closing bound check. One request is in work at a
// time; the next one is taken while a finished response still waits.
`include "assert_macros.svh"
module next_prime_at_least_core #(
   parameter int TABLE_ENTRIES = npal_pkg::DEF_TABLE_ENTRIES
) (
   input  logic         clock,
   input  logic         reset,
   npal_req_if.sink     req_ch,
   npal_rsp_if.source   rsp_ch
);
   import npal_pkg::*;

   npal_cmd_type cmd;
   npal_sts_type sts;
   logic         fail_rsp;
   logic         size_high;

   npal_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   npal_dpath #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_dpath (
      .clock      (clock),
      .cmd        (cmd),
      .sts        (sts),
      .min_size   (req_ch.min_size),
      .prime_size (rsp_ch.prime_size),
      .found      (rsp_ch.found)
   );

   assign fail_rsp  = rsp_ch.valid && !rsp_ch.found;
   assign size_high = rsp_ch.prime_size >= 31'd2147483630;

   // A failed search only happens when no odd candidate remains below the search limit.
   `NPAL_ASSERT_IMP(a_fail_high, clock, reset, fail_rsp, size_high)
   // Every reported prime is odd.
   `NPAL_ASSERT_IMP(a_prime_odd, clock, reset, rsp_ch.valid && rsp_ch.found, rsp_ch.prime_size[0])
   // Taking a request starts work, so the request side closes in the next cycle.
   `NPAL_ASSERT_NEXT(a_busy_after_take, clock, reset, req_ch.valid && req_ch.ready, !req_ch.ready)

endmodule

// ===== sv/npal_dpath.sv =====
// Datapath of the prime size lookup: table scan, candidate and divisor registers, remainder unit.
module npal_dpath #(
   parameter int TABLE_ENTRIES = npal_pkg::DEF_TABLE_ENTRIES
) (
   input  logic                                clock,
   input  npal_pkg::npal_cmd_type              cmd,
   output npal_pkg::npal_sts_type              sts,
   input  logic [npal_pkg::MIN_W-1:0]          min_size,
   output logic [npal_pkg::SIZE_W-1:0]         prime_size,
   output logic                                found
);
   import npal_pkg::*;

   localparam int SCAN_LEN = (TABLE_ENTRIES > LIST_LEN) ? LIST_LEN : TABLE_ENTRIES;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SCAN_LEN - 1);

   logic [MIN_W-1:0]   min_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic [SIZE_W-1:0]  cand_ff;
   logic [DIV_W-1:0]   div_ff;
   logic [SQ_W-1:0]    sq_ff;
   logic [DIV_W-1:0]   rem_ff;
   logic [BIT_W-1:0]   bit_ff;
   logic [SIZE_W-1:0]  res_ff;
   logic               res_found_ff;
   logic [SIZE_W-1:0]  out_size_ff;
   logic               out_found_ff;

   logic [ENTRY_W-1:0] entry;
   logic [DIV_W:0]     trial;
   logic               fits;
   logic [DIV_W-1:0]   rem_in;

   assign entry = PRIME_LIST[idx_ff];
   assign trial = {rem_ff, cand_ff[bit_ff]};
   assign fits  = trial >= {1'b0, div_ff};
   assign rem_in = fits ? DIV_W'(trial - {1'b0, div_ff}) : trial[DIV_W-1:0];

   always_comb begin
      sts.scan_hit      = min_ff[MIN_W-1] || (MIN_W'(entry) >= min_ff);
      sts.scan_last     = idx_ff == LAST_IDX;
      sts.min_small     = min_ff[MIN_W-1] || (min_ff < MIN_W'(2));
      sts.cand_at_limit = cand_ff == SEARCH_LIMIT;
      sts.sq_over       = sq_ff > {1'b0, cand_ff};
      sts.rem_last      = bit_ff == '0;
      sts.rem_zero      = rem_ff == '0;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         min_ff <= min_size;
         idx_ff <= '0;
      end
      if (cmd.scan_next) begin
         idx_ff <= idx_ff + IDX_W'(1);
      end
      if (cmd.set_table) begin
         res_ff       <= SIZE_W'(entry);
         res_found_ff <= 1'b1;
      end
      if (cmd.set_fail) begin
         res_ff       <= min_ff[SIZE_W-1:0];
         res_found_ff <= 1'b0;
      end
      if (cmd.set_prime) begin
         res_ff       <= cand_ff;
         res_found_ff <= 1'b1;
      end
      if (cmd.start_cand) begin
         cand_ff <= min_ff[SIZE_W-1:0] | SIZE_W'(1);
      end
      if (cmd.next_cand) begin
         cand_ff <= cand_ff + SIZE_W'(2);
      end
      if (cmd.init_div) begin
         div_ff <= FIRST_DIV;
         sq_ff  <= FIRST_SQ;
      end
      if (cmd.next_div) begin
         div_ff <= div_ff + DIV_W'(2);
         sq_ff  <= sq_ff + SQ_W'({div_ff, 2'b00}) + SQ_W'(4);
      end
      if (cmd.start_rem) begin
         rem_ff <= '0;
         bit_ff <= CAND_MSB;
      end
      if (cmd.rem_step) begin
         rem_ff <= rem_in;
         bit_ff <= bit_ff - BIT_W'(1);
      end
      if (cmd.load_out) begin
         out_size_ff  <= res_ff;
         out_found_ff <= res_found_ff;
      end
   end

   assign prime_size = out_size_ff;
   assign found      = out_found_ff;

endmodule

// ===== sv/npal_ctrl.sv =====
// Controller state machine of the prime size lookup.
module npal_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  npal_pkg::npal_sts_type  sts,
   output npal_pkg::npal_cmd_type  cmd
);
   import npal_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_CAND   = 3'd2;
   localparam logic [2:0] ST_TEST   = 3'd3;
   localparam logic [2:0] ST_DIV    = 3'd4;
   localparam logic [2:0] ST_CHECK  = 3'd5;
   localparam logic [2:0] ST_FINISH = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (sts.scan_hit) begin
               cmd.set_table = 1'b1;
               state_in      = ST_FINISH;
            end else if (sts.scan_last) begin
               if (sts.min_small) begin
                  cmd.set_fail = 1'b1;
                  state_in     = ST_FINISH;
               end else begin
                  cmd.start_cand = 1'b1;
                  state_in       = ST_CAND;
               end
            end else begin
               cmd.scan_next = 1'b1;
            end
         end
         ST_CAND: begin
            if (sts.cand_at_limit) begin
               cmd.set_fail = 1'b1;
               state_in     = ST_FINISH;
            end else begin
               cmd.init_div = 1'b1;
               state_in     = ST_TEST;
            end
         end
         ST_TEST: begin
            if (sts.sq_over) begin
               cmd.set_prime = 1'b1;
               state_in      = ST_FINISH;
            end else begin
               cmd.start_rem = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.rem_step = 1'b1;
            if (sts.rem_last) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (sts.rem_zero) begin
               cmd.next_cand = 1'b1;
               state_in      = ST_CAND;
            end else begin
               cmd.next_div = 1'b1;
               state_in     = ST_TEST;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule
